### rtl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Types and codes shared by the sorted list engine and its cells.
// ----------------------------------------------------------------------------
package sle_pkg;

	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic                      opcode;
		logic signed [VALUE_W-1:0] value;
	} req_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic [COUNT_W-1:0]        count;
		logic signed [VALUE_W-1:0] smallest;
		logic signed [VALUE_W-1:0] largest;
		logic                      nonempty;
	} rsp_item_t;

	// control broadcast from the sequencer to every cell
	typedef struct packed {
		logic cmp_en;
		logic upd_en;
		logic insert;
	} cell_ctl_t;

endpackage

### rtl/sle_cell.sv
// ----------------------------------------------------------------------------
// sle_cell
// One slot of the ordered list: holds an entry, compares it with the
// operand and shifts up or down with its neighbors.
// ----------------------------------------------------------------------------
module sle_cell (
	input  logic                              clk,
	input  sle_pkg::cell_ctl_t                ctl,
	input  logic                              occupied,
	input  logic signed [sle_pkg::VALUE_W-1:0] operand,
	input  logic                              left_le,
	input  logic signed [sle_pkg::VALUE_W-1:0] left_entry,
	input  logic signed [sle_pkg::VALUE_W-1:0] right_entry,
	output logic signed [sle_pkg::VALUE_W-1:0] entry,
	output logic                              le,
	output logic                              lt,
	output logic                              eq
);
	import sle_pkg::*;

	logic signed [VALUE_W-1:0] entry_q;
	logic                      le_s1;
	logic                      lt_s1;
	logic                      eq_s1;

	always_ff @(posedge clk) begin
		if (ctl.cmp_en) begin
			le_s1 <= occupied && (entry_q <= operand);
			lt_s1 <= occupied && (entry_q < operand);
			eq_s1 <= occupied && (entry_q == operand);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.upd_en) begin
			if (ctl.insert) begin
				// entries above the insertion point move up, the first one takes the operand
				if (!le_s1) begin
					entry_q <= left_le ? operand : left_entry;
				end
			end else begin
				// entries from the match upward take their right neighbor
				if (!lt_s1) begin
					entry_q <= right_entry;
				end
			end
		end
	end

	assign entry = entry_q;
	assign le    = le_s1;
	assign lt    = lt_s1;
	assign eq    = eq_s1;

endmodule

### rtl/sorted_list_engine.sv
// ----------------------------------------------------------------------------
// sorted_list_engine
// Ordered list of signed 32-bit values held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one operation: opcode
//   insert or remove, and the value. rsp channel (rsp_valid/rsp_ready/rsp)
//   returns exactly one result per operation: status, count after the
//   operation, smallest and largest entry (zero when empty) and nonempty.
//   At acceptance every cell compares its entry with the value in
//   parallel; in the update state that follows, all cells shift at once
//   (unless the operation fails) and the result is loaded into the output
//   register, which raises rsp_valid. The next operation is accepted only
//   once its update is done; the update can hold as described below.
//   A result waiting in the output register does not block the next
//   acceptance; if it is still not taken when the next update is due, the
//   update holds until rsp_ready frees the register.
//   Reset (arst_n low) empties the list at once; stored entry values are
//   not cleared since only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module sorted_list_engine #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  sle_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output sle_pkg::rsp_item_t rsp
);
	import sle_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_UPD  = 1'b1;

	logic                      state_q;
	logic [CNT_W-1:0]          count_q;
	logic                      op_s1;
	logic signed [VALUE_W-1:0] value_s1;
	logic signed [VALUE_W-1:0] top_s1;
	logic signed [VALUE_W-1:0] second_s1;
	logic                      rsp_valid_q;
	rsp_item_t                 rsp_q;

	logic signed [VALUE_W-1:0] entry_w [DEPTH];
	logic [DEPTH-1:0]          le_w;
	logic [DEPTH-1:0]          lt_w;
	logic [DEPTH-1:0]          eq_w;
	logic [DEPTH-1:0]          occ_w;
	logic [DEPTH-1:0]          top_sel;
	logic [DEPTH-1:0]          second_sel;
	logic signed [VALUE_W-1:0] top_mux;
	logic signed [VALUE_W-1:0] second_mux;
	logic signed [VALUE_W-1:0] operand;

	logic                      accept;
	logic                      go;
	logic                      found;
	logic                      is_full;
	logic                      is_empty;
	logic                      ins_ok;
	logic                      rem_ok;
	cell_ctl_t                 ctl;
	logic [STATUS_W-1:0]       status_nx;
	logic [CNT_W-1:0]          count_nx;
	logic signed [VALUE_W-1:0] small_nx;
	logic signed [VALUE_W-1:0] large_nx;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign go        = (state_q == ST_UPD) && (!rsp_valid_q || rsp_ready);

	// operand is the incoming value while comparing, the held value while shifting
	assign operand = (state_q == ST_IDLE) ? req.value : value_s1;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			occ_w[i]      = (i < int'(count_q));
			top_sel[i]    = (int'(count_q) == i + 1);
			second_sel[i] = (int'(count_q) == i + 2);
		end
	end

	always_comb begin
		top_mux    = '0;
		second_mux = '0;
		for (int i = 0; i < DEPTH; i++) begin
			top_mux    = top_mux | (entry_w[i] & {VALUE_W{top_sel[i]}});
			second_mux = second_mux | (entry_w[i] & {VALUE_W{second_sel[i]}});
		end
	end

	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);
	assign found    = |eq_w;
	assign ins_ok   = (op_s1 == OP_INSERT) && !is_full;
	assign rem_ok   = (op_s1 == OP_REMOVE) && !is_empty && found;

	assign ctl.cmp_en = accept;
	assign ctl.upd_en = go && (ins_ok || rem_ok);
	assign ctl.insert = (op_s1 == OP_INSERT);

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			logic                      left_le;
			logic signed [VALUE_W-1:0] left_entry;
			logic signed [VALUE_W-1:0] right_entry;

			if (g == 0) begin : g_first
				assign left_le    = 1'b1;
				assign left_entry = entry_w[g];
			end else begin : g_mid
				assign left_le    = le_w[g-1];
				assign left_entry = entry_w[g-1];
			end

			if (g == DEPTH - 1) begin : g_last
				assign right_entry = entry_w[g];
			end else begin : g_inner
				assign right_entry = entry_w[g+1];
			end

			sle_cell u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.occupied    (occ_w[g]),
				.operand     (operand),
				.left_le     (left_le),
				.left_entry  (left_entry),
				.right_entry (right_entry),
				.entry       (entry_w[g]),
				.le          (le_w[g]),
				.lt          (lt_w[g]),
				.eq          (eq_w[g])
			);
		end
	endgenerate

	always_comb begin
		status_nx = ST_OK;
		count_nx  = count_q;
		small_nx  = entry_w[0];
		large_nx  = top_s1;
		if (op_s1 == OP_INSERT) begin
			if (is_full) begin
				status_nx = ST_FULL;
			end else begin
				count_nx = count_q + CNT_W'(1);
				small_nx = le_w[0] ? entry_w[0] : value_s1;
				large_nx = (is_empty || (value_s1 >= top_s1)) ? value_s1 : top_s1;
			end
		end else begin
			if (is_empty) begin
				status_nx = ST_EMPTY;
			end else if (!found) begin
				status_nx = ST_NOT_FOUND;
			end else begin
				count_nx = count_q - CNT_W'(1);
				small_nx = lt_w[0] ? entry_w[0] : entry_w[1];
				large_nx = (value_s1 == top_s1) ? second_s1 : top_s1;
			end
		end
		if (count_nx == '0) begin
			small_nx = '0;
			large_nx = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (go) begin
				count_q     <= count_nx;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= req.opcode;
			value_s1  <= req.value;
			top_s1    <= top_mux;
			second_s1 <= second_mux;
		end
		if (go) begin
			rsp_q.status   <= status_nx;
			rsp_q.count    <= COUNT_W'(count_nx);
			rsp_q.smallest <= small_nx;
			rsp_q.largest  <= large_nx;
			rsp_q.nonempty <= (count_nx != '0);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count beyond depth");

	a_rsp_after_upd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_UPD))
		else $error("result raised without an update");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(go && ins_ok) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not grow the list");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD && !go) |=> (state_q == ST_UPD && $stable(count_q)))
		else $error("update went ahead while output was blocked");
`endif

endmodule

### dv/sorted_list_engine_tb.sv
// ----------------------------------------------------------------------------
// sorted_list_engine_tb
// Drives insert and remove operations into the sorted list engine and checks
// every result against a queue-based shadow of the list or a fixed expected
// result. A short table walks the corner cases (empty, full, extremes,
// duplicates, absent values); then random traffic, biased in phases toward
// filling or draining the list, runs with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module sorted_list_engine_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import sle_pkg::*;

	localparam int LIST_DEPTH   = 16;
	localparam int RANDOM_OPS   = 400;
	localparam int WDOG_LIMIT   = 2000;
	localparam int HOLD_AT      = 200;
	localparam int HOLD_CYCLES  = 120;

	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam logic signed [VALUE_W-1:0] VAL_A   = 32'shaaaa_aaaa;
	localparam logic signed [VALUE_W-1:0] VAL_5   = 32'sh5555_5555;

	typedef enum int {
		RDY_ALWAYS,
		RDY_MOSTLY,
		RDY_SELDOM,
		RDY_EVERY_THIRD
	} rdy_mode_t;

	typedef struct {
		req_item_t op;
		bit        typed;
		rsp_item_t want;
	} list_case_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_item_t req       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_item_t rsp;

	logic signed [VALUE_W-1:0] shadow_list[$];
	rsp_item_t                 awaited_results[$];
	list_case_t                corner_cases[$];

	int   fail_cnt     = 0;
	int   burst_left   = 0;
	logic rsp_holding  = 1'b0;

	sorted_list_engine #(
		.DEPTH(LIST_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #2 clk = ~clk;

	// shadow of the list: apply one operation and return the result it gives
	function automatic rsp_item_t apply_to_shadow_list(req_item_t it);
		rsp_item_t r;
		int        pos;
		r = '0;
		pos = 0;
		if (it.opcode == OP_INSERT) begin
			if (shadow_list.size() >= LIST_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				// new value goes after any equal entries
				while (pos < shadow_list.size() && shadow_list[pos] <= it.value)
					pos++;
				shadow_list.insert(pos, it.value);
				r.status = ST_OK;
			end
		end else if (shadow_list.size() == 0) begin
			r.status = ST_EMPTY;
		end else begin
			while (pos < shadow_list.size() && shadow_list[pos] < it.value)
				pos++;
			if (pos == shadow_list.size() || shadow_list[pos] != it.value) begin
				r.status = ST_NOT_FOUND;
			end else begin
				shadow_list.delete(pos);
				r.status = ST_OK;
			end
		end
		r.count    = COUNT_W'(shadow_list.size());
		r.nonempty = (shadow_list.size() != 0);
		if (r.nonempty) begin
			r.smallest = shadow_list[0];
			r.largest  = shadow_list[$];
		end
		return r;
	endfunction

	// random operation, leaning on the current list contents for removes
	function automatic req_item_t pick_list_op(int insert_pct);
		req_item_t it;
		int        sel;
		int        idx;
		it.opcode = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
		sel = $urandom_range(9);
		idx = (shadow_list.size() != 0) ? $urandom_range(shadow_list.size() - 1) : 0;
		if (it.opcode == OP_REMOVE && shadow_list.size() != 0 && sel < 6) begin
			it.value = shadow_list[idx];
		end else if (it.opcode == OP_REMOVE && shadow_list.size() != 0 && sel == 6) begin
			// near miss: neighbor of a stored value
			it.value = shadow_list[idx] + 1;
		end else if (sel < 4) begin
			// narrow range, lots of duplicates
			it.value = int'($urandom_range(8)) - 4;
		end else if (sel == 7) begin
			it.value = $urandom_range(1) ? VAL_MAX : VAL_MIN;
		end else begin
			it.value = $urandom;
		end
		return it;
	endfunction

	task automatic add_case(logic op, logic signed [VALUE_W-1:0] v, bit typed,
		rsp_item_t want);
		list_case_t c;
		c.op.opcode = op;
		c.op.value  = v;
		c.typed     = typed;
		c.want      = want;
		corner_cases.push_back(c);
	endtask

	// offer one item, wait for it to be taken, record what it must produce
	task automatic issue_list_op(req_item_t it, bit typed, rsp_item_t want);
		rsp_item_t model;
		req       <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		model = apply_to_shadow_list(it);
		awaited_results.push_back(typed ? want : model);
		if (burst_left != 0 || rsp_holding) begin
			if (burst_left != 0)
				burst_left--;
		end else begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(3) == 0) ? 40 : $urandom_range(0, 12);
		end
	endtask

	task automatic note_mismatch(string what, logic [VALUE_W-1:0] want,
		logic [VALUE_W-1:0] got);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("mismatch %s: expected %0h got %0h", what, want, got);
	endtask

	initial begin
		int        insert_pct;
		req_item_t it;

		add_case(OP_REMOVE, 32'sd5, 1'b1, '{ST_EMPTY, 5'd0, 32'sd0, 32'sd0, 1'b0});
		add_case(OP_INSERT, VAL_MIN, 1'b1, '{ST_OK, 5'd1, VAL_MIN, VAL_MIN, 1'b1});
		add_case(OP_INSERT, VAL_MAX, 1'b1, '{ST_OK, 5'd2, VAL_MIN, VAL_MAX, 1'b1});
		add_case(OP_REMOVE, 32'sd0, 1'b1, '{ST_NOT_FOUND, 5'd2, VAL_MIN, VAL_MAX, 1'b1});
		add_case(OP_INSERT, 32'sd0, 1'b0, '0);
		add_case(OP_INSERT, 32'sd0, 1'b0, '0);
		add_case(OP_INSERT, -32'sd1, 1'b0, '0);
		add_case(OP_REMOVE, 32'sd0, 1'b0, '0);
		add_case(OP_REMOVE, VAL_MIN, 1'b0, '0);
		add_case(OP_REMOVE, VAL_MAX, 1'b0, '0);
		// fill to the top from two entries
		add_case(OP_INSERT, VAL_A, 1'b0, '0);
		add_case(OP_INSERT, VAL_5, 1'b0, '0);
		for (int i = 2; i < LIST_DEPTH - 2; i++)
			add_case(OP_INSERT, (i - 7) * 1000, 1'b0, '0);
		add_case(OP_INSERT, 32'sd3, 1'b1, '{ST_FULL, 5'd16, VAL_A, VAL_5, 1'b1});
		add_case(OP_REMOVE, 32'sd12345, 1'b0, '0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_cases[i])
			issue_list_op(corner_cases[i].op, corner_cases[i].typed, corner_cases[i].want);

		insert_pct = 50;
		for (int n = 0; n < RANDOM_OPS; n++) begin
			// phases that push toward full or toward empty
			if (n % 40 == 0)
				insert_pct = ($urandom_range(2) == 0) ? 85 : ($urandom_range(1) ? 50 : 20);
			it = pick_list_op(insert_pct);
			issue_list_op(it, 1'b0, '0);
		end
		req_valid <= 1'b0;

		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("sorted_list_engine_tb OK");
		end else begin
			$display("sorted_list_engine_tb NOT OK");
		end
		$finish;
	end

	// result side: check each taken item, then decide next cycle's ready
	always @(posedge clk) begin : rsp_side
		rsp_item_t want;
		int        results_seen;
		int        hold_cnt;
		bit        hold_done;
		int        mode_left;
		int        phase_cnt;
		rdy_mode_t ready_mode;

		if (rsp_valid && rsp_ready) begin
			results_seen++;
			if (awaited_results.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= 10)
					$display("result with nothing pending: %0h", rsp);
			end else begin
				want = awaited_results.pop_front();
				if (rsp.status !== want.status)
					note_mismatch("status", want.status, rsp.status);
				if (rsp.count !== want.count)
					note_mismatch("count", want.count, rsp.count);
				if (rsp.smallest !== want.smallest)
					note_mismatch("smallest", want.smallest, rsp.smallest);
				if (rsp.largest !== want.largest)
					note_mismatch("largest", want.largest, rsp.largest);
				if (rsp.nonempty !== want.nonempty)
					note_mismatch("nonempty", want.nonempty, rsp.nonempty);
			end
		end

		// one long hold-off so the engine backs up into its input
		if (!hold_done && results_seen == HOLD_AT) begin
			hold_done = 1'b1;
			hold_cnt  = HOLD_CYCLES;
		end
		phase_cnt++;
		if (hold_cnt != 0) begin
			hold_cnt--;
			rsp_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = rdy_mode_t'($urandom_range(3));
				mode_left  = $urandom_range(20, 80);
			end
			mode_left--;
			case (ready_mode)
				RDY_ALWAYS:  rsp_ready <= 1'b1;
				RDY_MOSTLY:  rsp_ready <= ($urandom_range(9) < 7);
				RDY_SELDOM:  rsp_ready <= ($urandom_range(3) == 0);
				default:     rsp_ready <= (phase_cnt % 3 == 0);
			endcase
		end
		rsp_holding <= (hold_cnt != 0);
	end

	always @(posedge clk) begin : watchdog
		int idle_cycles;
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", WDOG_LIMIT);
				$display("sorted_list_engine_tb NOT OK");
				$finish;
			end
		end
	end

endmodule

### sorted_list_engine.f
rtl/sle_pkg.sv
rtl/sle_cell.sv
rtl/sorted_list_engine.sv
dv/sorted_list_engine_tb.sv
